@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising clock edge outside reset
`define SKV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define SKV_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/skv_pkg.sv @@
// types and codes of the sorted key/value table
package skv_pkg;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_SET  = 2'd1,
    ACT_GET  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_WARN      = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    action_t            action;
    logic        [31:0] key;
    logic signed [31:0] new_value;
    logic               warn_enable;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic        [31:0] key;
    logic signed [31:0] value;
    logic               mark;
  } entry_t;

endpackage

@@ rtl/sorted_key_value_table.sv @@
// sorted key/value table: a search is a binary search, each probe reading the middle entry.
// an item after an init that added an entry first runs an insertion sort through the
// single ram read port, shifting each larger entry up one slot.
// action code 3 gives its result the cycle after it is taken; busy stays high otherwise.
// done marks each result for one cycle. synchronous reset empties the table at once.
`include "assert_macros.svh"
module sorted_key_value_table
  import skv_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_I, S_GET_I, S_CMP, S_PLACE, S_SRCH, S_SCMP
  } state_t;

  state_t        state, state_next;
  req_t          item, item_next;
  entry_t        cur, cur_next;
  logic [CW-1:0] count, count_next;
  logic          sorted, sorted_next;
  logic [CW-1:0] i, i_next, j, j_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic          done_next;
  rsp_t          rsp_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [EW-1:0] rdata_raw;
  logic          adv;
  logic [CW-1:0] i_inc, span;

  assign ram_rdata = entry_t'(rdata_raw);
  assign busy      = (state != S_IDLE);
  assign i_inc     = i + CW'(1);
  assign span      = hi - lo;

  skv_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    state_next  = state;
    item_next   = item;
    cur_next    = cur;
    count_next  = count;
    sorted_next = sorted;
    i_next      = i;
    j_next      = j;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    done_next   = 1'b0;
    rsp_next    = rsp;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = cur;
    ram_raddr   = '0;
    adv         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          item_next = req;
          if (req.action == ACT_NONE) begin
            done_next = 1'b1;
            rsp_next  = '{read_value: '0, status: ST_OK};
          end else if (!sorted && count > CW'(1)) begin
            i_next     = CW'(1);
            state_next = S_RD_I;
          end else begin
            sorted_next = 1'b1;
            lo_next     = '0;
            hi_next     = count;
            state_next  = S_SRCH;
          end
        end
      end
      S_RD_I: begin
        ram_raddr  = i[AW-1:0];
        state_next = S_GET_I;
      end
      S_GET_I: begin
        cur_next   = ram_rdata;
        j_next     = i;
        ram_raddr  = AW'(i - CW'(1));
        state_next = S_CMP;
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        if (ram_rdata.key > cur.key) begin
          // shift the larger entry up one slot
          ram_wdata = ram_rdata;
          j_next    = j - CW'(1);
          if (j > CW'(1)) begin
            ram_raddr = AW'(j - CW'(2));
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          ram_wdata = cur;
          adv       = 1'b1;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = cur;
        adv       = 1'b1;
      end
      S_SRCH: begin
        if (lo < hi) begin
          mid_next   = lo + (span >> 1);
          ram_raddr  = mid_next[AW-1:0];
          state_next = S_SCMP;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          rsp_next   = '{read_value: '0, status: ST_NOT_FOUND};
          if (item.action == ACT_INIT) begin
            if (count >= FULL) begin
              rsp_next.status = ST_FULL;
            end else begin
              rsp_next.status = ST_OK;
              ram_we      = 1'b1;
              ram_waddr   = count[AW-1:0];
              ram_wdata   = '{key: item.key, value: item.new_value, mark: 1'b0};
              count_next  = count + CW'(1);
              sorted_next = 1'b0;
            end
          end
        end
      end
      S_SCMP: begin
        if (ram_rdata.key == item.key) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          rsp_next   = '{read_value: '0, status: ST_OK};
          ram_waddr  = mid[AW-1:0];
          ram_wdata  = ram_rdata;
          case (item.action)
            ACT_INIT: begin
              ram_we          = 1'b1;
              ram_wdata.value = item.new_value;
            end
            ACT_SET: begin
              ram_we          = 1'b1;
              ram_wdata.value = item.new_value;
              ram_wdata.mark  = 1'b1;
            end
            default: begin
              rsp_next.read_value = ram_rdata.value;
              if (item.warn_enable && !ram_rdata.mark) begin
                ram_we          = 1'b1;
                ram_wdata.mark  = 1'b1;
                rsp_next.status = ST_WARN;
              end
            end
          endcase
        end else begin
          if (ram_rdata.key < item.key) begin
            lo_next = mid + CW'(1);
          end else begin
            hi_next = mid;
          end
          state_next = S_SRCH;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // next insertion pass or start of the search
    if (adv) begin
      i_next = i_inc;
      if (i_inc < count) begin
        state_next = S_RD_I;
      end else begin
        sorted_next = 1'b1;
        lo_next     = '0;
        hi_next     = count;
        state_next  = S_SRCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      sorted <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      sorted <= sorted_next;
      done   <= done_next;
    end
    item <= item_next;
    cur  <= cur_next;
    i    <= i_next;
    j    <= j_next;
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    rsp  <= rsp_next;
  end

  `SKV_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")
  `SKV_NEVER(a_count_range, clk, rst, count > FULL, "entry count beyond table size")
  `SKV_ASSERT(a_accept_moves, clk, rst, (start && !busy) |=> (busy || done),
              "accepted item neither worked on nor answered")
  `SKV_ASSERT(a_full_only_full, clk, rst, (done && rsp.status == ST_FULL) |-> (count == FULL),
              "table full reported with free entries")

endmodule

@@ rtl/skv_ram.sv @@
// generic single write port ram with registered read
module skv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
